// File: rtl/gb5_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gb5_pkg;

    // Frame size limits
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;

    localparam int COL_W  = $clog2(MAX_WIDTH);       // column index
    localparam int WID_W  = $clog2(MAX_WIDTH + 1);   // clamped width value
    localparam int ROW_W  = $clog2(MAX_HEIGHT + 3);  // input row, runs past the frame
    localparam int OROW_W = $clog2(MAX_HEIGHT);      // output row
    localparam int HGT_W  = $clog2(MAX_HEIGHT + 1);  // clamped height value

    localparam int PIX_W  = 8;
    localparam int LINES  = 4;
    localparam int LINE_W = LINES * PIX_W;

    // Configuration register map
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 13;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = CFG_INDEX_W'(1);
    localparam int FRAME_WIDTH_W  = 11;
    localparam int FRAME_HEIGHT_W = 13;
    localparam int MIN_SIDE       = 5;
    localparam int RESET_WIDTH    = 640;
    localparam int RESET_HEIGHT   = 480;

    // Item kinds
    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    // Kernel weights, grouped by symmetry
    localparam int WT_CORNER = 2;
    localparam int WT_EDGE4  = 4;
    localparam int WT_AXIS5  = 5;
    localparam int WT_DIAG9  = 9;
    localparam int WT_NEAR12 = 12;
    localparam int WT_CENTRE = 15;

    // floor(s / 159) = (s * DIV_RECIP) >> DIV_SHIFT for every s below 2^16
    localparam int SUM_W     = 16;
    localparam int DIV_SHIFT = 24;
    localparam int RECIP_W   = 17;
    localparam logic [RECIP_W-1:0] DIV_RECIP = RECIP_W'(105518);
    localparam int PROD_W    = SUM_W + RECIP_W;
    localparam int QUOT_W    = PROD_W - DIV_SHIFT;
    localparam logic [PIX_W-1:0] PIX_MAX = '1;

    // Result queue
    localparam int OUT_DEPTH = 8;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    typedef struct packed {
        logic             kind;
        logic [PIX_W-1:0] pixel_in;
    } t_in_item;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             frame_last;
    } t_out_item;

    // 5x5 window, [row][column], column 4 newest, row 4 current input row
    typedef logic [4:0][4:0][PIX_W-1:0] t_window;

    typedef struct packed {
        logic             valid;
        logic             interior;
        logic             last;
        logic [PIX_W-1:0] border;
    } t_kctl;

endpackage

`default_nettype wire

// File: rtl/gb5_kernel.sv
`timescale 1ns / 1ps
`default_nettype none

module gb5_kernel (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  gb5_pkg::t_window     i_win,
    input  gb5_pkg::t_kctl       i_ctl,
    output logic                 o_valid,
    output gb5_pkg::t_out_item   o_item
);
    import gb5_pkg::*;

    localparam int G4_W = PIX_W + 2;
    localparam int G8_W = PIX_W + 3;

    // Stage 1: sums of pixels that share a weight
    logic [G4_W-1:0] r_g_corner, r_g_axis5, r_g_diag9, r_g_near12;
    logic [G8_W-1:0] r_g_edge4;
    logic [PIX_W-1:0] r_g_centre;
    // Stage 2: weighted total; stage 3: reciprocal product
    logic [SUM_W-1:0]  r_sum;
    logic [PROD_W-1:0] r_prod;
    t_kctl r_ctl1, r_ctl2, r_ctl3;

    logic [QUOT_W-1:0] quot;

    always_ff @(posedge i_clk) begin
        r_g_corner <= G4_W'(i_win[0][0]) + G4_W'(i_win[0][4])
                    + G4_W'(i_win[4][0]) + G4_W'(i_win[4][4]);
        r_g_edge4  <= G8_W'(i_win[0][1]) + G8_W'(i_win[0][3])
                    + G8_W'(i_win[1][0]) + G8_W'(i_win[1][4])
                    + G8_W'(i_win[3][0]) + G8_W'(i_win[3][4])
                    + G8_W'(i_win[4][1]) + G8_W'(i_win[4][3]);
        r_g_axis5  <= G4_W'(i_win[0][2]) + G4_W'(i_win[2][0])
                    + G4_W'(i_win[2][4]) + G4_W'(i_win[4][2]);
        r_g_diag9  <= G4_W'(i_win[1][1]) + G4_W'(i_win[1][3])
                    + G4_W'(i_win[3][1]) + G4_W'(i_win[3][3]);
        r_g_near12 <= G4_W'(i_win[1][2]) + G4_W'(i_win[2][1])
                    + G4_W'(i_win[2][3]) + G4_W'(i_win[3][2]);
        r_g_centre <= i_win[2][2];

        r_sum <= SUM_W'(r_g_corner) * SUM_W'(WT_CORNER)
               + SUM_W'(r_g_edge4)  * SUM_W'(WT_EDGE4)
               + SUM_W'(r_g_axis5)  * SUM_W'(WT_AXIS5)
               + SUM_W'(r_g_diag9)  * SUM_W'(WT_DIAG9)
               + SUM_W'(r_g_near12) * SUM_W'(WT_NEAR12)
               + SUM_W'(r_g_centre) * SUM_W'(WT_CENTRE);

        r_prod <= PROD_W'(r_sum) * PROD_W'(DIV_RECIP);

        o_item.frame_last <= r_ctl3.last;
        if (r_ctl3.interior) begin
            o_item.pixel_out <= (quot > QUOT_W'(PIX_MAX)) ? PIX_MAX : quot[PIX_W-1:0];
        end else begin
            o_item.pixel_out <= r_ctl3.border;
        end
    end

    assign quot = r_prod[PROD_W-1:DIV_SHIFT];

    // Control travels alongside; only valid needs reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1.valid <= 1'b0;
            r_ctl2.valid <= 1'b0;
            r_ctl3.valid <= 1'b0;
            o_valid      <= 1'b0;
        end else begin
            r_ctl1.valid <= i_ctl.valid;
            r_ctl2.valid <= r_ctl1.valid;
            r_ctl3.valid <= r_ctl2.valid;
            o_valid      <= r_ctl3.valid;
        end
        r_ctl1.interior <= i_ctl.interior;
        r_ctl1.last     <= i_ctl.last;
        r_ctl1.border   <= i_ctl.border;
        r_ctl2.interior <= r_ctl1.interior;
        r_ctl2.last     <= r_ctl1.last;
        r_ctl2.border   <= r_ctl1.border;
        r_ctl3.interior <= r_ctl2.interior;
        r_ctl3.last     <= r_ctl2.last;
        r_ctl3.border   <= r_ctl2.border;
    end

endmodule

`default_nettype wire

// File: rtl/gb5_out_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module gb5_out_fifo (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_push,
    input  gb5_pkg::t_out_item   i_item,
    output logic                 o_valid,
    output gb5_pkg::t_out_item   o_item,
    input  wire                  i_ready
);
    import gb5_pkg::*;

    t_out_item r_slot [OUT_DEPTH];
    // One wrap bit above the index tells full from empty
    logic [OUT_PTR_W:0] r_wr_ptr, r_rd_ptr;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr[OUT_PTR_W-1:0]] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (o_valid && i_ready) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    assign o_valid = (r_wr_ptr != r_rd_ptr);
    assign o_item  = r_slot[r_rd_ptr[OUT_PTR_W-1:0]];

endmodule

`default_nettype wire

// File: rtl/gaussian_blur_5x5_stream_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                   Payload
// input     in         i_in_valid / o_in_ready     i_in_item   {kind, pixel_in}
// result    out        o_out_valid / i_out_ready   o_out_item  {pixel_out, frame_last}
// config    in         i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// One item per clock sustained while the result side keeps up. Before a result can
// transfer it passes the line-store read, the window shift, then group sums, weighted
// total, reciprocal multiply, the output select and the result queue write. Up to 8
// results may be outstanding (in flight or queued); past that the input stalls until
// the result side takes a transfer.
// Synchronous active-low reset; no clearing pass, the line store starts unwritten.

module gaussian_blur_5x5_stream_core (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_in_valid,
    output logic                                  o_in_ready,
    input  gb5_pkg::t_in_item                     i_in_item,
    output logic                                  o_out_valid,
    input  wire                                   i_out_ready,
    output gb5_pkg::t_out_item                    o_out_item,
    input  wire                                   i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire  [gb5_pkg::CFG_INDEX_W-1:0]       i_cfg_index,
    input  wire  [gb5_pkg::CFG_DATA_W-1:0]        i_cfg_data
);
    import gb5_pkg::*;

    localparam logic [ROW_W-1:0] ROW_TWO = ROW_W'(2);
    localparam logic [COL_W-1:0] COL_TWO = COL_W'(2);
    localparam logic [OROW_W-1:0] OROW_TWO = OROW_W'(2);

    // ---------------------------------------------------------------------
    // Configuration: store the clamped size with its handy offsets
    // ---------------------------------------------------------------------
    logic [COL_W-1:0]  r_width_m1, r_width_m2;
    logic [HGT_W-1:0]  r_height;
    logic [OROW_W-1:0] r_height_m1, r_height_m2;

    logic [FRAME_WIDTH_W-1:0]  cfg_w_raw;
    logic [FRAME_HEIGHT_W-1:0] cfg_h_raw;
    logic [WID_W-1:0]          cfg_w;
    logic [HGT_W-1:0]          cfg_h;
    logic cfg_wr;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign cfg_w_raw   = i_cfg_data[FRAME_WIDTH_W-1:0];
    assign cfg_h_raw   = i_cfg_data[FRAME_HEIGHT_W-1:0];

    always_comb begin
        if (cfg_w_raw < FRAME_WIDTH_W'(MIN_SIDE)) begin
            cfg_w = WID_W'(MIN_SIDE);
        end else if (cfg_w_raw > FRAME_WIDTH_W'(MAX_WIDTH)) begin
            cfg_w = WID_W'(MAX_WIDTH);
        end else begin
            cfg_w = WID_W'(cfg_w_raw);
        end
        if (cfg_h_raw < FRAME_HEIGHT_W'(MIN_SIDE)) begin
            cfg_h = HGT_W'(MIN_SIDE);
        end else if (cfg_h_raw > FRAME_HEIGHT_W'(MAX_HEIGHT)) begin
            cfg_h = HGT_W'(MAX_HEIGHT);
        end else begin
            cfg_h = HGT_W'(cfg_h_raw);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width_m1  <= COL_W'(RESET_WIDTH - 1);
            r_width_m2  <= COL_W'(RESET_WIDTH - 2);
            r_height    <= HGT_W'(RESET_HEIGHT);
            r_height_m1 <= OROW_W'(RESET_HEIGHT - 1);
            r_height_m2 <= OROW_W'(RESET_HEIGHT - 2);
        end else if (cfg_wr) begin
            case (i_cfg_index)
                REG_FRAME_WIDTH: begin
                    r_width_m1 <= COL_W'(cfg_w - WID_W'(1));
                    r_width_m2 <= COL_W'(cfg_w - WID_W'(2));
                end
                REG_FRAME_HEIGHT: begin
                    r_height    <= cfg_h;
                    r_height_m1 <= OROW_W'(cfg_h - HGT_W'(1));
                    r_height_m2 <= OROW_W'(cfg_h - HGT_W'(2));
                end
                default: begin
                end
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Intake: positions, border decisions and the result credit
    // ---------------------------------------------------------------------
    logic [COL_W-1:0]  r_in_col, r_out_col;
    logic [ROW_W-1:0]  r_in_row;
    logic [OROW_W-1:0] r_out_row;
    logic [OUT_CNT_W-1:0] r_pending, n_pending;

    logic in_xfer, in_frame, ignore, take, emit, col_end, out_col_end;
    logic interior, last, out_xfer;

    assign in_xfer  = i_in_valid && o_in_ready;
    assign out_xfer = o_out_valid && i_out_ready;
    assign in_frame = ROW_W'(r_in_row) < ROW_W'(r_height);
    // a flush before the last real pixel is taken and dropped
    assign ignore   = (i_in_item.kind == KIND_FLUSH) && in_frame;
    assign take     = in_xfer && !ignore;
    assign emit     = (r_in_row > ROW_TWO) || ((r_in_row == ROW_TWO) && (r_in_col >= COL_TWO));
    assign col_end  = (r_in_col == r_width_m1);
    assign out_col_end = (r_out_col == r_width_m1);
    assign interior = (r_out_row >= OROW_TWO) && (r_out_row < r_height_m2)
                   && (r_out_col >= COL_TWO) && (r_out_col < r_width_m2);
    assign last     = (r_out_row == r_height_m1) && out_col_end;

    assign o_in_ready = (r_pending < OUT_CNT_W'(OUT_DEPTH));

    always_comb begin
        n_pending = r_pending;
        if (take && emit) begin
            n_pending = n_pending + 1'b1;
        end
        if (out_xfer) begin
            n_pending = n_pending - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= n_pending;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_wr) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else if (take) begin
            if (emit && last) begin
                // frame done: restart every position for the next frame
                r_in_col  <= '0;
                r_in_row  <= '0;
                r_out_col <= '0;
                r_out_row <= '0;
            end else begin
                if (col_end) begin
                    r_in_col <= '0;
                    r_in_row <= r_in_row + 1'b1;
                end else begin
                    r_in_col <= r_in_col + 1'b1;
                end
                if (emit) begin
                    if (out_col_end) begin
                        r_out_col <= '0;
                        r_out_row <= r_out_row + 1'b1;
                    end else begin
                        r_out_col <= r_out_col + 1'b1;
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Line store: one word per column, four rows packed, newest row lowest.
    // Read at intake, write back the shifted column in the cycle after. Two
    // consecutive items never share a column (width is at least five), so
    // the write-back never meets a read of the same entry.
    // ---------------------------------------------------------------------
    logic [LINE_W-1:0] r_line_mem [MAX_WIDTH];
    logic [LINE_W-1:0] r_rd_data;

    // second stage registers
    logic             r_b_valid, r_b_emit;
    logic [COL_W-1:0] r_b_x;
    logic [PIX_W-1:0] r_b_px;
    logic             r_b_interior, r_b_last;
    logic             r_b_first, r_b_second, r_b_cap_m2, r_b_cap_m1;

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_rd_data <= r_line_mem[r_in_col];
        end
        if (r_b_valid) begin
            r_line_mem[r_b_x] <= {r_rd_data[LINE_W-PIX_W-1:0], r_b_px};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= take;
        end
        r_b_emit     <= emit;
        r_b_x        <= r_in_col;
        // pixels in the tail enter as zero
        r_b_px       <= in_frame ? i_in_item.pixel_in : '0;
        r_b_interior <= interior;
        r_b_last     <= last;
        r_b_first    <= (r_in_col == '0);
        r_b_second   <= (r_in_col == COL_W'(1));
        r_b_cap_m2   <= (r_in_col == r_width_m2);
        r_b_cap_m1   <= col_end;
    end

    // ---------------------------------------------------------------------
    // Window shift and border pixels
    // ---------------------------------------------------------------------
    t_window r_win;
    logic [PIX_W-1:0] col_in [5];
    logic [PIX_W-1:0] r_edge0, r_edge1;
    logic [PIX_W-1:0] border;
    t_kctl r_kctl;

    // oldest row first, current input row last
    assign col_in[0] = r_rd_data[4*PIX_W-1:3*PIX_W];
    assign col_in[1] = r_rd_data[3*PIX_W-1:2*PIX_W];
    assign col_in[2] = r_rd_data[2*PIX_W-1:PIX_W];
    assign col_in[3] = r_rd_data[PIX_W-1:0];
    assign col_in[4] = r_b_px;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (r_b_valid) begin
            for (int r = 0; r < 5; r++) begin
                for (int c = 0; c < 4; c++) begin
                    r_win[r][c] <= r_win[r][c+1];
                end
                r_win[r][4] <= col_in[r];
            end
        end
    end

    // Hold the last two pixels of the row two up; the first two outputs of
    // the next row fall on them
    always_ff @(posedge i_clk) begin
        if (r_b_valid && r_b_cap_m2) begin
            r_edge0 <= col_in[2];
        end
        if (r_b_valid && r_b_cap_m1) begin
            r_edge1 <= col_in[2];
        end
    end

    always_comb begin
        if (r_b_first) begin
            border = r_edge0;
        end else if (r_b_second) begin
            border = r_edge1;
        end else begin
            border = r_win[2][3];   // centre once the window has shifted
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kctl.valid <= 1'b0;
        end else begin
            r_kctl.valid <= r_b_valid && r_b_emit;
        end
        r_kctl.interior <= r_b_interior;
        r_kctl.last     <= r_b_last;
        r_kctl.border   <= border;
    end

    // ---------------------------------------------------------------------
    // Kernel arithmetic and result queue
    // ---------------------------------------------------------------------
    logic      res_valid;
    t_out_item res_item;

    gb5_kernel u_kernel (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_win   (r_win),
        .i_ctl   (r_kctl),
        .o_valid (res_valid),
        .o_item  (res_item)
    );

    gb5_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_item  (res_item),
        .o_valid (o_out_valid),
        .o_item  (o_out_item),
        .i_ready (i_out_ready)
    );

endmodule

`default_nettype wire

// File: tb/gb5_stream_checker.sv
`timescale 1ns / 1ps

// Predicts the blurred stream from the observed input and configuration transfers
// and compares each result transfer against the oldest prediction.
module gb5_stream_checker (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_in_valid,
    input  wire                              i_in_ready,
    input  gb5_pkg::t_in_item                i_in_item,
    input  wire                              i_out_valid,
    input  wire                              i_out_ready,
    input  gb5_pkg::t_out_item               i_out_item,
    input  wire                              i_cfg_valid,
    input  wire                              i_cfg_ready,
    input  wire [gb5_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  wire [gb5_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output int                               o_fail_count,
    output int                               o_pending
);
    import gb5_pkg::*;

    localparam int unsigned BLUR_DIVISOR = 159;
    localparam int          SHOWN_LIMIT  = 10;

    int unsigned blur_weight [5][5] = '{
        '{WT_CORNER, WT_EDGE4,  WT_AXIS5,  WT_EDGE4,  WT_CORNER},
        '{WT_EDGE4,  WT_DIAG9,  WT_NEAR12, WT_DIAG9,  WT_EDGE4 },
        '{WT_AXIS5,  WT_NEAR12, WT_CENTRE, WT_NEAR12, WT_AXIS5 },
        '{WT_EDGE4,  WT_DIAG9,  WT_NEAR12, WT_DIAG9,  WT_EDGE4 },
        '{WT_CORNER, WT_EDGE4,  WT_AXIS5,  WT_EDGE4,  WT_CORNER}
    };

    // Shadow of the block state
    logic [PIX_W-1:0]          line_mem [LINES][MAX_WIDTH];
    logic [PIX_W-1:0]          win [5][5];
    int unsigned               in_col, in_row, out_col, out_row;
    logic [FRAME_WIDTH_W-1:0]  width_reg;
    logic [FRAME_HEIGHT_W-1:0] height_reg;

    t_out_item expected_pixels [$];
    int        mismatches;
    int        results_seen;

    assign o_fail_count = mismatches;

    function automatic int unsigned fit_side(int unsigned v, int unsigned hi);
        return (v < MIN_SIDE) ? MIN_SIDE : ((v > hi) ? hi : v);
    endfunction

    function automatic void restart_frame();
        in_col  = 0;
        in_row  = 0;
        out_col = 0;
        out_row = 0;
    endfunction

    function automatic void flag_mismatch(string what, int want, int got);
        mismatches++;
        if (mismatches <= SHOWN_LIMIT) begin
            $display("mismatch on result %0d (%s): expected %0d, got %0d at %0t",
                     results_seen, what, want, got, $time);
        end
    endfunction

    // Advance the shadow by one input transfer; return 1 with the blurred pixel if one is due
    function automatic bit blur_next(input t_in_item it, output t_out_item res);
        int unsigned      w, h, x, y, orow, ocol, sum, value, r, k;
        logic [PIX_W-1:0] px, edge_px;
        logic [PIX_W-1:0] column [5];
        bit               due, last;
        w       = fit_side(width_reg, MAX_WIDTH);
        h       = fit_side(height_reg, MAX_HEIGHT);
        y       = in_row;
        x       = in_col;
        res     = '0;
        edge_px = '0;
        if (x >= w) x = w - 1;
        // Flush inside the frame: drop it untouched
        if (it.kind == KIND_FLUSH && y < h) return 1'b0;
        px = (y < h) ? it.pixel_in : '0;
        if (x < 2) edge_px = line_mem[2][w - 2 + x];
        column[0] = line_mem[3][x];
        column[1] = line_mem[2][x];
        column[2] = line_mem[1][x];
        column[3] = line_mem[0][x];
        column[4] = px;
        for (r = 0; r < 5; r++) begin
            for (k = 0; k < 4; k++) win[r][k] = win[r][k + 1];
            win[r][4] = column[r];
        end
        line_mem[3][x] = column[1];
        line_mem[2][x] = column[2];
        line_mem[1][x] = column[3];
        line_mem[0][x] = px;
        due    = (y > 2) || (y == 2 && x >= 2);
        in_col = x + 1;
        if (in_col >= w) begin
            in_col = 0;
            in_row = y + 1;
        end
        if (!due) return 1'b0;

        orow = out_row;
        ocol = out_col;
        if (orow >= 2 && orow < h - 2 && ocol >= 2 && ocol < w - 2) begin
            sum = 0;
            for (r = 0; r < 5; r++)
                for (k = 0; k < 5; k++) sum += blur_weight[r][k] * win[r][k];
            value = sum / BLUR_DIVISOR;
            if (value > PIX_MAX) value = PIX_MAX;
        end else begin
            value = (x >= 2) ? win[2][2] : edge_px;
        end
        last           = (orow == h - 1) && (ocol == w - 1);
        res.pixel_out  = value[PIX_W-1:0];
        res.frame_last = last;
        out_col        = ocol + 1;
        if (out_col >= w) begin
            out_col = 0;
            out_row = orow + 1;
        end
        if (last) restart_frame();
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_out_item want;
        t_out_item got;
        if (!i_rst_n) begin
            width_reg  = FRAME_WIDTH_W'(RESET_WIDTH);
            height_reg = FRAME_HEIGHT_W'(RESET_HEIGHT);
            for (int l = 0; l < LINES; l++)
                for (int c = 0; c < MAX_WIDTH; c++) line_mem[l][c] = '0;
            for (int r = 0; r < 5; r++)
                for (int c = 0; c < 5; c++) win[r][c] = '0;
            restart_frame();
            expected_pixels.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                results_seen++;
                if (expected_pixels.size() == 0) begin
                    flag_mismatch("result with nothing outstanding", -1, i_out_item.pixel_out);
                end else begin
                    want = expected_pixels.pop_front();
                    if (i_out_item.pixel_out !== want.pixel_out)
                        flag_mismatch("pixel_out", want.pixel_out, i_out_item.pixel_out);
                    if (i_out_item.frame_last !== want.frame_last)
                        flag_mismatch("frame_last", want.frame_last, i_out_item.frame_last);
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_FRAME_WIDTH: begin
                        width_reg = i_cfg_data[FRAME_WIDTH_W-1:0];
                        restart_frame();
                    end
                    REG_FRAME_HEIGHT: begin
                        height_reg = i_cfg_data[FRAME_HEIGHT_W-1:0];
                        restart_frame();
                    end
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                if (blur_next(i_in_item, got)) expected_pixels.push_back(got);
            end
        end
        o_pending <= expected_pixels.size();
    end

endmodule

// File: tb/tb_gaussian_blur_5x5_stream_core.sv
`timescale 1ns / 1ps

module tb_gaussian_blur_5x5_stream_core;

    import gb5_pkg::*;

    localparam int RANDOM_ITEMS = 1350;  // pixel and tail transfers over the whole run
    localparam int HOLD_OFF     = 12;    // cycles to let the pipeline empty before a write
    localparam int TRAIL_CYCLES = 40;    // quiet time at the end to catch stray results
    localparam int STALL_LIMIT  = 4000;  // cycles without any transfer before giving up

    // Drive every input to a known value from time zero
    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   in_valid  = 1'b0;
    t_in_item               in_item   = '0;
    logic                   out_ready = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    logic      in_ready;
    logic      out_valid;
    t_out_item out_item;
    logic      cfg_ready;
    int        fail_count;
    int        pending;

    int sender_idle_pct = 0;
    int out_stall_pct   = 0;
    int quiet_cycles    = 0;
    int fed_items       = 0;
    int frame_w         = RESET_WIDTH;
    int frame_h         = RESET_HEIGHT;

    gaussian_blur_5x5_stream_core DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    gb5_stream_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_item   (out_item),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    // Result side: stall at random, one decision per falling edge
    always @(negedge clk) begin
        out_ready <= ($urandom_range(99) >= out_stall_pct);
    end

    // Watchdog: count cycles in which no channel completes a transfer
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic int side_of(int v, int hi);
        return (v < MIN_SIDE) ? MIN_SIDE : ((v > hi) ? hi : v);
    endfunction

    // Bias towards the extremes so that saturation and black both show up
    function automatic logic [PIX_W-1:0] pick_pixel();
        case ($urandom_range(9))
            0:       return '0;
            1:       return PIX_MAX;
            default: return PIX_W'($urandom_range(255));
        endcase
    endfunction

    task automatic set_idling(input int send_pct, input int stall_pct);
        sender_idle_pct = send_pct;
        out_stall_pct   = stall_pct;
    endtask

    // Offer one item, called at a falling edge; return at the falling edge after its transfer.
    // Valid is left high, so back-to-back items keep it up without dropping it between them.
    task automatic feed(input logic kind, input logic [PIX_W-1:0] pix);
        while ($urandom_range(99) < sender_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= t_in_item'{kind: kind, pixel_in: pix};
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    // Hold the input until every predicted result has left, then let the pipeline run dry
    task automatic settle();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (HOLD_OFF) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
        case (idx)
            REG_FRAME_WIDTH:  frame_w = side_of(data[FRAME_WIDTH_W-1:0], MAX_WIDTH);
            REG_FRAME_HEIGHT: frame_h = side_of(data[FRAME_HEIGHT_W-1:0], MAX_HEIGHT);
            default: ;
        endcase
    endtask

    // Reconfigure between frames; optionally hit an unmapped register index too
    task automatic set_frame(input int w_data, input int h_data, input bit stray);
        settle();
        write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(w_data));
        write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(h_data));
        if (stray)
            write_reg(CFG_INDEX_W'($urandom_range(REG_FRAME_HEIGHT + 1, (1 << CFG_INDEX_W) - 1)),
                      CFG_DATA_W'($urandom));
    endtask

    // Send pixel_count pixels of a frame; a complete frame is followed by its tail
    task automatic send_frame(input int pixel_count, input bit noisy);
        for (int i = 0; i < pixel_count; i++) begin
            // Flush inside the frame: the block must ignore it
            if (noisy && $urandom_range(24) == 0) feed(KIND_FLUSH, pick_pixel());
            feed(KIND_PIXEL, pick_pixel());
        end
        fed_items += pixel_count;
        if (pixel_count == frame_w * frame_h) begin
            // Tail: mostly flushes, a few real pixels whose values are dropped
            for (int i = 0; i < 2 * frame_w + 2; i++) begin
                if ($urandom_range(99) < 15)
                    feed(KIND_PIXEL, pick_pixel());
                else
                    feed(KIND_FLUSH, pick_pixel());
            end
            fed_items += 2 * frame_w + 2;
            // Flushes once the frame is done change nothing
            repeat ($urandom_range(2)) feed(KIND_FLUSH, pick_pixel());
        end
    endtask

    initial begin
        int  w_data, h_data, full, count;
        int  frame_no;
        bit  need_cfg;

        set_idling(0, 0);
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: smallest frame, saturated content, flush inside the frame,
        // real pixels in the tail, flushes after the frame is done, an unmapped register write
        set_frame(MIN_SIDE, MIN_SIDE, 1'b0);
        write_reg('1, '1);
        for (int i = 0; i < MIN_SIDE * MIN_SIDE; i++) begin
            if (i == 12) feed(KIND_FLUSH, '0);
            feed(KIND_PIXEL, PIX_MAX);
        end
        for (int i = 0; i < 2 * MIN_SIDE + 2; i++) begin
            if (i == 3)
                feed(KIND_PIXEL, '0);
            else if (i == 8)
                feed(KIND_PIXEL, PIX_MAX);
            else
                feed(KIND_FLUSH, PIX_MAX);
        end
        feed(KIND_FLUSH, '0);
        feed(KIND_FLUSH, PIX_MAX);

        // Widest frame: width over the top clamps to the largest line, shortest height.
        // Send a quarter of the first row only; nothing may come out yet.
        set_frame((1 << CFG_DATA_W) - 1, MIN_SIDE, 1'b0);
        send_frame(frame_w / 4, 1'b0);

        // Tallest frame: height over the top clamps; cut it short after a dozen rows.
        // Width data carries set bits above the register field.
        set_frame((3 << FRAME_WIDTH_W) | MIN_SIDE, (1 << CFG_DATA_W) - 1, 1'b0);
        send_frame(12 * frame_w, 1'b0);

        // Random frames, rotating through the idling phases
        frame_no  = 0;
        need_cfg  = 1'b1;
        while (fed_items < RANDOM_ITEMS) begin
            case (frame_no % 4)
                0:       set_idling(0, 0);
                1:       set_idling(86, 0);
                2:       set_idling(0, 86);
                default: set_idling(25, 25);
            endcase
            if (need_cfg || $urandom_range(3) != 0) begin
                case ($urandom_range(9))
                    0:       w_data = $urandom_range(MIN_SIDE - 1);
                    1:       w_data = $urandom_range(40, 13);
                    default: w_data = $urandom_range(12, MIN_SIDE);
                endcase
                if ($urandom_range(3) == 0)
                    w_data |= $urandom_range(3, 1) << FRAME_WIDTH_W;
                h_data = ($urandom_range(9) == 0) ? $urandom_range(MIN_SIDE - 1)
                                                  : $urandom_range(9, MIN_SIDE);
                set_frame(w_data, h_data, $urandom_range(6) == 0);
            end
            full = frame_w * frame_h;
            // Now and then break the frame off and force a fresh start
            if ($urandom_range(11) == 0) begin
                count    = $urandom_range(full - 1, 1);
                need_cfg = 1'b1;
            end else begin
                count    = full;
                need_cfg = 1'b0;
            end
            send_frame(count, 1'b1);
            frame_no++;
        end

        // Drain: no more input, wait for every outstanding result, then watch for extras
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (TRAIL_CYCLES) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
